[rtl/core/tmbg_pkg.sv]
// shared types and constants of the tempo map beat grid generator
package tmbg_pkg;
    localparam int TEMPO_DEPTH        = 64;
    localparam int SIGNATURE_DEPTH    = 64;
    localparam int TIME_FRACTION_BITS = 16;
    localparam int TADDR_W            = $clog2(TEMPO_DEPTH);
    localparam int SADDR_W            = $clog2(SIGNATURE_DEPTH);
    localparam int TCNT_W             = $clog2(TEMPO_DEPTH + 1);
    localparam int SCNT_W             = $clog2(SIGNATURE_DEPTH + 1);
    localparam int ACC_W              = (TIME_FRACTION_BITS >= 16) ? 64 : 48 + TIME_FRACTION_BITS;
    localparam int NUM_W              = 38 + TIME_FRACTION_BITS;
    localparam int DEN_W              = 28;
    localparam int DIV_CNT_W          = $clog2(NUM_W + 1);
    localparam logic [16:0] WALK_LIMIT = 17'd65536;

    localparam logic [2:0] REQ_CLEAR  = 3'd0;
    localparam logic [2:0] REQ_TEMPO  = 3'd1;
    localparam logic [2:0] REQ_SIG    = 3'd2;
    localparam logic [2:0] REQ_REWIND = 3'd3;
    localparam logic [2:0] REQ_NEXT   = 3'd4;

    localparam logic [1:0] ST_POINT = 2'd0;
    localparam logic [1:0] ST_OK    = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [1:0] CFG_RATE  = 2'd0;
    localparam logic [1:0] CFG_MODE  = 2'd1;
    localparam logic [1:0] CFG_START = 2'd2;

    typedef struct packed {
        logic [15:0] bar;
        logic [7:0]  beat;
        logic [19:0] bpm;
    } t_tempo;

    typedef struct packed {
        logic [15:0] bar;
        logic [7:0]  num;
        logic [7:0]  den;
    } t_sig;
endpackage

[rtl/core/tempo_map_beat_grid_generator_unit.sv]
// top level: tables in memories, request sequencer and grid walk
//  channel | signals                          | direction
//  in      | i_valid, o_stall, i_req_type..   | item in
//  out     | o_valid, i_stall, o_grid_time..  | item out
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data| register write
// a control request's result is held pending, then moved into the output register
// a next request walks beats through the sequencer states and the 54-step serial divider,
// reading further table entries as needed, for up to 65536 beats
// reset is synchronous; tables hold garbage until appended and are guarded by counts
// no item is taken while a request is in progress, a result is pending or the output register is stalled
module tempo_map_beat_grid_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_node_bar,
    input  logic [7:0]  i_node_beat,
    input  logic [19:0] i_bpm_milli,
    input  logic [7:0]  i_sig_numerator,
    input  logic [7:0]  i_sig_denominator,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [47:0] o_grid_time,
    output logic [15:0] o_bar_number,
    output logic [7:0]  o_beat_number,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_BEAT  = 9'b000000010,
        S_SRD   = 9'b000000100,
        S_SCHK  = 9'b000001000,
        S_TRD   = 9'b000010000,
        S_TCHK  = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_WAIT  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state;
    tmbg_pkg::t_tempo r_tmem [tmbg_pkg::TEMPO_DEPTH];
    tmbg_pkg::t_sig   r_smem [tmbg_pkg::SIGNATURE_DEPTH];
    tmbg_pkg::t_tempo r_trd;
    tmbg_pkg::t_sig   r_srd;
    logic [tmbg_pkg::TADDR_W-1:0] r_taddr;
    logic [tmbg_pkg::SADDR_W-1:0] r_saddr;
    logic [tmbg_pkg::TCNT_W-1:0]  r_tcnt, r_tcur;
    logic [tmbg_pkg::SCNT_W-1:0]  r_scnt, r_scur;
    logic [15:0] r_bar;
    logic [7:0]  r_beat, r_num, r_den;
    logic [tmbg_pkg::ACC_W-1:0] r_acc;
    logic [18:0] r_rate;
    logic        r_mode;
    logic [47:0] r_start;
    logic [16:0] r_walk;
    logic        r_hit, r_busy;
    logic [47:0] r_gt;
    logic [15:0] r_pbar;
    logic [7:0]  r_pbeat;
    logic        r_pend;
    logic [1:0]  r_pst;
    logic        r_div_go;
    logic [tmbg_pkg::NUM_W-1:0] r_dnum;
    logic [tmbg_pkg::DEN_W-1:0] r_dden;
    logic        w_done;
    logic [tmbg_pkg::NUM_W-1:0] w_quot;
    logic [tmbg_pkg::ACC_W:0]   w_sum;
    logic [47:0] w_gt;
    logic        w_acc;

    tmbg_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go), .i_num(r_dnum),
        .i_den(r_dden), .o_done(w_done), .o_quot(w_quot));

    assign w_acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || r_pend || (o_valid && i_stall);
    assign w_sum = {1'b0, r_acc} + {1'b0, tmbg_pkg::ACC_W'(w_quot)};
    assign w_gt  = 48'(r_acc >> tmbg_pkg::TIME_FRACTION_BITS);

    always_ff @(posedge i_clk) begin
        r_trd <= r_tmem[r_taddr];
        r_srd <= r_smem[r_saddr];
        if (w_acc && i_req_type == tmbg_pkg::REQ_TEMPO && r_tcnt < tmbg_pkg::TEMPO_DEPTH)
            r_tmem[r_tcnt[tmbg_pkg::TADDR_W-1:0]] <= '{i_node_bar, i_node_beat,
                (i_bpm_milli == 20'd0) ? 20'd1 : i_bpm_milli};
        if (w_acc && i_req_type == tmbg_pkg::REQ_SIG && r_scnt < tmbg_pkg::SIGNATURE_DEPTH)
            r_smem[r_scnt[tmbg_pkg::SADDR_W-1:0]] <= '{i_node_bar,
                (i_sig_numerator == 8'd0) ? 8'd1 : i_sig_numerator,
                (i_sig_denominator == 8'd0) ? 8'd1 : i_sig_denominator};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tcnt <= '0; r_scnt <= '0; r_tcur <= '0; r_scur <= '0;
            r_bar <= '0; r_beat <= '0; r_acc <= '0;
            r_rate <= 19'd48000; r_mode <= 1'b0; r_start <= '0;
            o_valid <= 1'b0; r_pend <= 1'b0; r_div_go <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tmbg_pkg::CFG_RATE:  r_rate  <= i_cfg_data[18:0];
                    tmbg_pkg::CFG_MODE:  r_mode  <= i_cfg_data[0];
                    tmbg_pkg::CFG_START: r_start <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_pend && (!o_valid || !i_stall)) begin
                o_valid <= 1'b1; r_pend <= 1'b0;
                o_status <= r_pst; o_grid_time <= r_gt;
                o_bar_number <= r_pbar; o_beat_number <= r_pbeat;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (w_acc) begin
                    r_gt <= '0; r_pbar <= '0; r_pbeat <= '0;
                    unique case (i_req_type)
                        tmbg_pkg::REQ_CLEAR: begin
                            r_tcnt <= '0; r_scnt <= '0; r_tcur <= '0; r_scur <= '0;
                            r_bar <= '0; r_beat <= '0; r_acc <= '0; r_pend <= 1'b1;
                            r_pst <= tmbg_pkg::ST_OK;
                        end
                        tmbg_pkg::REQ_TEMPO: begin
                            r_pend <= 1'b1;
                            if (r_tcnt < tmbg_pkg::TEMPO_DEPTH) begin
                                r_tcnt <= r_tcnt + 1'b1;
                                r_pst <= tmbg_pkg::ST_OK;
                            end else r_pst <= tmbg_pkg::ST_FULL;
                        end
                        tmbg_pkg::REQ_SIG: begin
                            r_pend <= 1'b1;
                            if (r_scnt < tmbg_pkg::SIGNATURE_DEPTH) begin
                                r_scnt <= r_scnt + 1'b1;
                                r_pst <= tmbg_pkg::ST_OK;
                            end else r_pst <= tmbg_pkg::ST_FULL;
                        end
                        tmbg_pkg::REQ_REWIND: begin
                            r_tcur <= '0; r_scur <= '0;
                            r_bar <= '0; r_beat <= '0; r_acc <= '0; r_pend <= 1'b1;
                            r_pst <= tmbg_pkg::ST_OK;
                        end
                        tmbg_pkg::REQ_NEXT: begin
                            if (r_tcnt == '0 || r_scnt == '0) begin
                                r_pst <= tmbg_pkg::ST_EMPTY; r_pend <= 1'b1;
                            end else begin
                                r_walk <= '0; r_state <= S_BEAT;
                            end
                        end
                        default: ;
                    endcase
                end
                S_BEAT: begin
                    if (r_walk == tmbg_pkg::WALK_LIMIT) r_state <= S_IDLE;
                    else begin
                        if (r_beat == 8'd0) begin
                            if (r_bar != 16'hFFFF) r_bar <= r_bar + 1'b1;
                            r_beat <= 8'd1;
                        end
                        r_saddr <= tmbg_pkg::SADDR_W'(r_scur + 1'b1);
                        r_busy <= (r_beat == 8'd0);
                        r_state <= S_SRD;
                    end
                end
                S_SRD: r_state <= S_SCHK;
                S_SCHK: begin
                    if (r_busy && r_scur + 1'b1 < r_scnt && r_srd.bar == r_bar) begin
                        r_scur <= r_scur + 1'b1;
                        r_saddr <= tmbg_pkg::SADDR_W'(r_scur + 2'd2);
                        r_state <= S_SRD;
                    end else begin
                        r_saddr <= tmbg_pkg::SADDR_W'(r_scur);
                        r_taddr <= tmbg_pkg::TADDR_W'(r_tcur + 1'b1);
                        r_state <= S_TRD;
                    end
                end
                S_TRD: begin
                    r_busy <= 1'b0;
                    r_state <= S_TCHK;
                end
                S_TCHK: begin
                    if (r_saddr == tmbg_pkg::SADDR_W'(r_scur)) begin
                        r_num <= r_srd.num; r_den <= r_srd.den;
                        r_saddr <= ~r_saddr;
                    end
                    if (r_tcur + 1'b1 < r_tcnt && (r_trd.bar < r_bar ||
                            (r_trd.bar == r_bar && r_trd.beat == r_beat))) begin
                        r_tcur <= r_tcur + 1'b1;
                        r_taddr <= tmbg_pkg::TADDR_W'(r_tcur + 2'd2);
                        r_state <= S_TRD;
                    end else begin
                        r_taddr <= tmbg_pkg::TADDR_W'(r_tcur);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (r_taddr == tmbg_pkg::TADDR_W'(r_tcur) && !r_busy) begin
                        r_busy <= 1'b1;
                        r_dnum <= tmbg_pkg::NUM_W'((38'd240000 * r_rate))
                            << tmbg_pkg::TIME_FRACTION_BITS;
                        r_dden <= tmbg_pkg::DEN_W'(r_trd.bpm) * tmbg_pkg::DEN_W'(r_den);
                        r_div_go <= 1'b1;
                        r_hit <= (w_gt >= r_start) && (!r_mode || r_beat == 8'd1);
                        r_gt <= w_gt; r_pbar <= r_bar; r_pbeat <= r_beat;
                    end else begin
                        r_div_go <= 1'b0;
                        if (w_done) begin
                            r_busy <= 1'b0;
                            r_acc <= w_sum[tmbg_pkg::ACC_W] ? '1 : w_sum[tmbg_pkg::ACC_W-1:0];
                            r_beat <= (r_beat >= r_num) ? 8'd0 : r_beat + 1'b1;
                            r_walk <= r_walk + 1'b1;
                            if (r_hit) begin
                                r_pst <= tmbg_pkg::ST_POINT; r_state <= S_OUT;
                            end else r_state <= S_BEAT;
                        end
                    end
                end
                S_OUT: begin
                    r_pend <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/core/tmbg_div.sv]
// restoring divider for the beat duration, one quotient bit per cycle
module tmbg_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tmbg_pkg::NUM_W-1:0] i_num,
    input  logic [tmbg_pkg::DEN_W-1:0] i_den,
    output logic                       o_done,
    output logic [tmbg_pkg::NUM_W-1:0] o_quot
);
    logic [tmbg_pkg::NUM_W-1:0]     r_q;
    logic [tmbg_pkg::DEN_W:0]       r_rem;
    logic [tmbg_pkg::DEN_W-1:0]     r_den;
    logic [tmbg_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic [tmbg_pkg::DEN_W:0]       w_sh;
    logic                           w_ge;

    assign w_sh = {r_rem[tmbg_pkg::DEN_W-1:0], r_q[tmbg_pkg::NUM_W-1]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= tmbg_pkg::DIV_CNT_W'(tmbg_pkg::NUM_W);
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sh - {1'b0, r_den} : w_sh;
                r_q   <= {r_q[tmbg_pkg::NUM_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == tmbg_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_q;
endmodule
